[rtl/core/bltb_pkg.sv]
// Package for the bilinear texture blend pixel unit.
// Holds the shared types, defaults and arithmetic helpers; depends on nothing.
package bltb_pkg;

  localparam int TEX_MAX_SIDE_DEF = 256;
  localparam int FRAC_BITS_DEF    = 8;

  // Operation codes of an input item.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SHADE = 1'b1;

  // Register indexes on the configuration channel.
  typedef enum logic [2:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_INV_DIM_X = 3'd2,
    REG_INV_DIM_Y = 3'd3,
    REG_COLOR     = 3'd4,
    REG_TEX_W     = 3'd5,
    REG_TEX_H     = 3'd6
  } reg_idx_t;

  localparam logic [23:0] ORIGIN_RST = 24'd0;
  localparam logic [24:0] INV_DIM_RST = 25'h1000000;
  localparam logic [31:0] COLOR_RST = 32'hFFFFFFFF;
  localparam logic [8:0]  TEX_SIZE_RST = 9'd256;
  localparam logic [15:0] CH_MAX = 16'd65025;
  localparam logic [31:0] RECIP_255 = 32'h01010101;

  typedef struct packed {
    logic [23:0] origin_x;
    logic [23:0] origin_y;
    logic [24:0] inv_dim_x;
    logic [24:0] inv_dim_y;
    logic [31:0] color_rgba;
    logic [8:0]  tex_width;
    logic [8:0]  tex_height;
  } cfg_t;

  // What travels beside the datapath for every pipeline slot.
  typedef struct packed {
    logic        valid;
    logic        shade;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [31:0] texel;
    logic [31:0] dest;
  } tag_t;

  typedef struct packed {
    logic [11:0] rem;
    logic [8:0]  root;
  } sq_t;

  // Estimate of y / 255 that is exact or one low.
  function automatic logic [25:0] div255_est(input logic [25:0] y);
    logic [57:0] p;
    p = {32'd0, y} * {26'd0, RECIP_255};
    return p[57:32];
  endfunction

  // Fixes the estimate up by one where the remainder is still 255 or more.
  function automatic logic [25:0] div255_fix(input logic [25:0] y, input logic [25:0] q);
    logic [25:0] r;
    r = y - ({q[17:0], 8'h00} - q);
    return (r >= 26'd255) ? q + 26'd1 : q;
  endfunction

  // One digit of the restoring square root.
  function automatic sq_t sqrt_step(input sq_t s, input logic [1:0] bits);
    sq_t        o;
    logic [11:0] rem;
    logic [11:0] trial;
    rem   = {s.rem[9:0], bits};
    trial = {1'b0, s.root, 2'b01};
    if (rem >= trial) begin
      o.rem  = rem - trial;
      o.root = {s.root[7:0], 1'b1};
    end else begin
      o.rem  = rem;
      o.root = {s.root[7:0], 1'b0};
    end
    return o;
  endfunction

endpackage

[rtl/core/bltb_if.sv]
// Channel interfaces of the bilinear texture blend pixel unit.
// Plain valid/ready channels; no package dependency.
interface bltb_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [11:0] pos_x;
  logic [11:0] pos_y;
  logic [31:0] texel_word;
  logic [31:0] dest_pixel;
  modport source (output valid, opcode, pos_x, pos_y, texel_word, dest_pixel, input ready);
  modport sink (input valid, opcode, pos_x, pos_y, texel_word, dest_pixel, output ready);
endinterface

interface bltb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_out;
  logic        write_enable;
  modport source (output valid, pixel_out, write_enable, input ready);
  modport sink (input valid, pixel_out, write_enable, output ready);
endinterface

interface bltb_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/bltb_map.sv]
// Maps one pixel axis to a fetch coordinate, a filter fraction and an in-quad flag.
// Three register stages; uses bltb_pkg only through the caller's widths.
module bltb_map #(
  parameter int TEX_MAX_SIDE = 256,
  parameter int FRAC_BITS    = 8
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [11:0]                     pos,
  input  logic [23:0]                     org,
  input  logic [24:0]                     inv,
  input  logic [8:0]                      size,
  output logic                            in_quad,
  output logic [$clog2(TEX_MAX_SIDE)-1:0] fetch,
  output logic [FRAC_BITS-1:0]            frac
);
  localparam int CW = $clog2(TEX_MAX_SIDE);

  logic signed [25:0] p1;
  logic signed [51:0] u2;
  logic [8:0]  size_c;
  logic [8:0]  sz2;
  logic        low;
  logic        is_one;
  logic        sat;
  logic [31:0] u32;
  logic [41:0] t;
  logic        in_quad_next;
  logic [CW-1:0] fetch_next;
  logic [FRAC_BITS-1:0] frac_next;

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= $signed({5'd0, pos, 8'h00}) - $signed({{2{org[23]}}, org});
      u2 <= p1 * $signed({1'b0, inv});
      in_quad <= in_quad_next;
      fetch <= fetch_next;
      frac <= frac_next;
    end
  end

  always_comb begin
    if (size < 9'd2) begin
      size_c = 9'd2;
    end else if ({4'd0, size} > 13'(TEX_MAX_SIDE)) begin
      size_c = 9'(TEX_MAX_SIDE);
    end else begin
      size_c = size;
    end
    sz2    = size_c - 9'd2;
    low    = (u2[51:32] == 20'd0);
    is_one = (u2[51:32] == 20'd1) && (u2[31:0] == 32'd0);
    // A positive U above one clamps to one; a negative one clamps to zero.
    sat    = !u2[51] && !low;
    in_quad_next = low || is_one;
    u32 = low ? u2[31:0] : 32'd0;
    t = {10'd0, u32} * {33'd0, sz2} + 42'h0_8000_0000;
    if (sat) begin
      fetch_next = CW'(sz2);
      frac_next  = {1'b1, {(FRAC_BITS-1){1'b0}}};
    end else begin
      fetch_next = CW'(t[41:32]);
      frac_next  = t[31 -: FRAC_BITS];
    end
  end
endmodule

[rtl/core/bltb_texmem.sv]
// Texture store split in four banks by texel column and row parity.
// One write and four reads per cycle while en is high, one read per bank; read data registered.
module bltb_texmem #(
  parameter int TEX_MAX_SIDE = 256
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic                            load,
  input  logic [11:0]                     wx,
  input  logic [11:0]                     wy,
  input  logic [31:0]                     wdata,
  input  logic [$clog2(TEX_MAX_SIDE)-1:0] rx,
  input  logic [$clog2(TEX_MAX_SIDE)-1:0] ry,
  output logic [31:0]                     tex [4]
);
  localparam int CW   = $clog2(TEX_MAX_SIDE);
  localparam int HALF = (TEX_MAX_SIDE + 1) / 2;
  localparam int HW   = $clog2(HALF);
  localparam int BD   = HALF * HALF;
  localparam int AW   = $clog2(BD);

  logic          we;
  logic [1:0]    wbank;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr [4];
  logic [CW-1:0] xs [4];
  logic [CW-1:0] ys [4];
  logic [31:0]   rd [4];
  logic          rx0;
  logic          ry0;

  always_comb begin
    we    = en && load && ({1'b0, wx} < 13'(TEX_MAX_SIDE)) &&
            ({1'b0, wy} < 13'(TEX_MAX_SIDE));
    wbank = {wy[0], wx[0]};
    waddr = AW'(HW'(wy[11:1]) * HALF + HW'(wx[11:1]));
    for (int b = 0; b < 4; b++) begin
      // Each bank holds exactly one of the four neighbors.
      xs[b] = (rx[0] == b[0]) ? rx : rx + CW'(1);
      ys[b] = (ry[0] == b[1]) ? ry : ry + CW'(1);
      raddr[b] = AW'(HW'(ys[b] >> 1) * HALF + HW'(xs[b] >> 1));
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [31:0] mem [BD];
    always_ff @(posedge clk) begin
      if (we && (wbank == 2'(b))) begin
        mem[waddr] <= wdata;
      end
      if (en) begin
        rd[b] <= mem[raddr[b]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx0 <= rx[0];
      ry0 <= ry[0];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      tex[i] = rd[{ry0 ^ i[1], rx0 ^ i[0]}];
    end
  end
endmodule

[rtl/core/bltb_filter.sv]
// Bilinear filter of squared texel color and of texel alpha.
// Weights at stage one, squares at two, products at three, rounded sums at four.
module bltb_filter #(
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [FRAC_BITS-1:0] fx,
  input  logic [FRAC_BITS-1:0] fy,
  input  logic [31:0]          tex [4],
  output logic [15:0]          tf [3],
  output logic [7:0]           ta
);
  localparam int F  = FRAC_BITS;
  localparam int WW = 2 * F + 2;
  localparam int PW = WW + 16;
  localparam int SW = WW + 18;

  logic [F:0]    one_c;
  logic [F:0]    wx [2];
  logic [F:0]    wy [2];
  logic [WW-1:0] w4 [4];
  logic [WW-1:0] w5 [4];
  logic [15:0]   sq5 [4][3];
  logic [7:0]    al5 [4];
  logic [PW-1:0] p6 [4][3];
  logic [PW-1:0] pa6 [4];
  logic [SW-1:0] sum [3];
  logic [SW-1:0] suma;
  logic [15:0]   tf_next [3];
  logic [7:0]    ta_next;

  always_comb begin
    one_c = {1'b1, {F{1'b0}}};
    wx[0] = one_c - {1'b0, fx};
    wx[1] = {1'b0, fx};
    wy[0] = one_c - {1'b0, fy};
    wy[1] = {1'b0, fy};
    suma = SW'(1) << (2 * F - 1);
    for (int i = 0; i < 4; i++) begin
      suma = suma + SW'(pa6[i]);
    end
    ta_next = suma[2 * F +: 8];
    for (int c = 0; c < 3; c++) begin
      sum[c] = SW'(1) << (2 * F - 1);
      for (int i = 0; i < 4; i++) begin
        sum[c] = sum[c] + SW'(p6[i][c]);
      end
      tf_next[c] = sum[c][2 * F +: 16];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        w4[i]  <= WW'(wx[i % 2] * wy[i / 2]);
        w5[i]  <= w4[i];
        al5[i] <= tex[i][31:24];
        pa6[i] <= PW'(w5[i] * al5[i]);
        for (int c = 0; c < 3; c++) begin
          sq5[i][c] <= tex[i][8 * c +: 8] * tex[i][8 * c +: 8];
          p6[i][c]  <= PW'(w5[i] * sq5[i][c]);
        end
      end
      tf <= tf_next;
      ta <= ta_next;
    end
  end
endmodule

[rtl/core/bltb_blend.sv]
// Tint, blend over the squared destination and rounded square root.
// Ten register stages; uses bltb_pkg for the divide by 255 and root steps.
module bltb_blend (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] tf [3],
  input  logic [7:0]  ta,
  input  logic [31:0] color,
  input  logic [31:0] dest,
  output logic [31:0] pix
);
  logic [25:0] y9 [3];
  logic [25:0] q9 [3];
  logic [25:0] ya9;
  logic [25:0] qa9;
  logic [15:0] m8a;
  logic [23:0] m8 [3];
  logic [15:0] dd8 [3];
  logic [15:0] dd9 [3];
  logic [15:0] dd10 [3];
  logic [7:0]  da [3];
  logic [15:0] tm10 [3];
  logic [7:0]  a10;
  logic [25:0] y11 [3];
  logic [25:0] ya11;
  logic [25:0] y12 [3];
  logic [25:0] q12 [3];
  logic [25:0] ya12;
  logic [25:0] qa12;
  logic [16:0] v13 [3];
  logic [17:0] v18 [3];
  logic [7:0]  ao [4];
  bltb_pkg::sq_t sq [3][3];
  logic [17:0]   vs [3][2];
  bltb_pkg::sq_t sq_next [3][3];
  logic [25:0]   tfix [3];
  logic [7:0]    rgb [3];
  logic [8:0]    rnd [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      tfix[c] = bltb_pkg::div255_fix(y9[c], q9[c]);
      v18[c] = {1'b0, v13[c]};
      sq_next[c][0] = '{rem: 12'd0, root: 9'd0};
      for (int j = 0; j < 3; j++) begin
        sq_next[c][0] = bltb_pkg::sqrt_step(sq_next[c][0], v18[c][17 - 2 * j -: 2]);
      end
      for (int s = 1; s < 3; s++) begin
        sq_next[c][s] = sq[c][s - 1];
        for (int j = 0; j < 3; j++) begin
          sq_next[c][s] = bltb_pkg::sqrt_step(sq_next[c][s],
              vs[c][s - 1][17 - 6 * s - 2 * j -: 2]);
        end
      end
      // Round half up: v above s*s+s means the root is nearer to s+1.
      rnd[c] = (sq[c][2].rem > {3'd0, sq[c][2].root}) ? sq[c][2].root + 9'd1 : sq[c][2].root;
      rgb[c] = (rnd[c] > 9'd255) ? 8'd255 : rnd[c][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m8a   <= ta * color[7:0];
      ya9   <= 26'(m8a) + 26'd127;
      qa9   <= bltb_pkg::div255_est(26'(m8a) + 26'd127);
      a10   <= 8'(bltb_pkg::div255_fix(ya9, qa9));
      da[0] <= dest[31:24];
      for (int k = 1; k < 3; k++) begin
        da[k] <= da[k - 1];
      end
      ya11  <= 26'(8'd255 - a10) * 26'(da[2]) + 26'(a10) * 26'd255 + 26'd127;
      ya12  <= ya11;
      qa12  <= bltb_pkg::div255_est(ya11);
      ao[0] <= 8'(bltb_pkg::div255_fix(ya12, qa12));
      for (int k = 1; k < 4; k++) begin
        ao[k] <= ao[k - 1];
      end
      for (int c = 0; c < 3; c++) begin
        m8[c]   <= tf[c] * color[8 * c + 8 +: 8];
        dd8[c]  <= dest[8 * c +: 8] * dest[8 * c +: 8];
        y9[c]   <= 26'(m8[c]) + 26'd127;
        q9[c]   <= bltb_pkg::div255_est(26'(m8[c]) + 26'd127);
        dd9[c]  <= dd8[c];
        dd10[c] <= dd9[c];
        tm10[c] <= (tfix[c] > 26'(bltb_pkg::CH_MAX)) ? bltb_pkg::CH_MAX : tfix[c][15:0];
        y11[c]  <= 26'(8'd255 - a10) * 26'(dd10[c]) + 26'(tm10[c]) * 26'd255 + 26'd127;
        y12[c]  <= y11[c];
        q12[c]  <= bltb_pkg::div255_est(y11[c]);
        v13[c]  <= 17'(bltb_pkg::div255_fix(y12[c], q12[c]));
        vs[c][0] <= {1'b0, v13[c]};
        vs[c][1] <= vs[c][0];
        for (int s = 0; s < 3; s++) begin
          sq[c][s] <= sq_next[c][s];
        end
      end
      pix <= {ao[3], rgb[2], rgb[1], rgb[0]};
    end
  end
endmodule

[rtl/core/bilinear_texture_blend_pixel_unit.sv]
// Top level of the bilinear texture blend pixel unit.
// Depends on bltb_pkg, the channel interfaces, bltb_map, bltb_texmem, bltb_filter, bltb_blend.
//
//  channel | role   | transfer moves
//  pix_in  | sink   | opcode, pos_x, pos_y, texel_word, dest_pixel
//  pix_out | source | pixel_out, write_enable
//  cfg     | sink   | index, data (always ready)
//
// One item enters per clock unless a stalled output holds it; a shade result leaves from the last tag stage.
// A load writes the texture store as it leaves the third tag stage and gives no result.
// The four banked texture reads happen in the same cycle, so the store never limits rate.
// A stalled output freezes all stages together; nothing is dropped or repeated.
// Reset clears the valid bits and restores the registers; the store stays unwritten.
module bilinear_texture_blend_pixel_unit #(
  parameter int TEX_MAX_SIDE = bltb_pkg::TEX_MAX_SIDE_DEF,
  parameter int FRAC_BITS    = bltb_pkg::FRAC_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  bltb_in_if.sink  pix_in,
  bltb_out_if.source pix_out,
  bltb_cfg_if.sink cfg
);
  localparam int CW    = $clog2(TEX_MAX_SIDE);
  localparam int DEPTH = 17;

  bltb_pkg::cfg_t cfg_q;
  bltb_pkg::tag_t tag_q [1:DEPTH];
  bltb_pkg::tag_t tag_in;
  logic           ins_q [4:DEPTH];
  logic           adv;
  logic           in_x;
  logic           in_y;
  logic [CW-1:0]  fetch_x;
  logic [CW-1:0]  fetch_y;
  logic [FRAC_BITS-1:0] frac_x;
  logic [FRAC_BITS-1:0] frac_y;
  logic [31:0]    tex [4];
  logic [15:0]    tf [3];
  logic [7:0]     ta;
  logic [31:0]    pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.origin_x   <= bltb_pkg::ORIGIN_RST;
      cfg_q.origin_y   <= bltb_pkg::ORIGIN_RST;
      cfg_q.inv_dim_x  <= bltb_pkg::INV_DIM_RST;
      cfg_q.inv_dim_y  <= bltb_pkg::INV_DIM_RST;
      cfg_q.color_rgba <= bltb_pkg::COLOR_RST;
      cfg_q.tex_width  <= bltb_pkg::TEX_SIZE_RST;
      cfg_q.tex_height <= bltb_pkg::TEX_SIZE_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        bltb_pkg::REG_ORIGIN_X:  cfg_q.origin_x   <= cfg.data[23:0];
        bltb_pkg::REG_ORIGIN_Y:  cfg_q.origin_y   <= cfg.data[23:0];
        bltb_pkg::REG_INV_DIM_X: cfg_q.inv_dim_x  <= cfg.data[24:0];
        bltb_pkg::REG_INV_DIM_Y: cfg_q.inv_dim_y  <= cfg.data[24:0];
        bltb_pkg::REG_COLOR:     cfg_q.color_rgba <= cfg.data;
        bltb_pkg::REG_TEX_W:     cfg_q.tex_width  <= cfg.data[8:0];
        bltb_pkg::REG_TEX_H:     cfg_q.tex_height <= cfg.data[8:0];
        default: ;
      endcase
    end
  end

  assign cfg.ready = 1'b1;

  // The last stage is the output register; everything moves when it can drain.
  assign adv          = !(tag_q[DEPTH].valid && tag_q[DEPTH].shade) || pix_out.ready;
  assign pix_in.ready = adv;

  always_comb begin
    tag_in.valid = pix_in.valid;
    tag_in.shade = (pix_in.opcode == bltb_pkg::OP_SHADE);
    tag_in.pos_x = pix_in.pos_x;
    tag_in.pos_y = pix_in.pos_y;
    tag_in.texel = pix_in.texel_word;
    tag_in.dest  = pix_in.dest_pixel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= DEPTH; k++) begin
        tag_q[k].valid <= 1'b0;
      end
    end else if (adv) begin
      tag_q[1].valid <= tag_in.valid;
      for (int k = 2; k <= DEPTH; k++) begin
        tag_q[k].valid <= tag_q[k - 1].valid;
      end
    end
    if (adv) begin
      tag_q[1].shade <= tag_in.shade;
      tag_q[1].pos_x <= tag_in.pos_x;
      tag_q[1].pos_y <= tag_in.pos_y;
      tag_q[1].texel <= tag_in.texel;
      tag_q[1].dest  <= tag_in.dest;
      for (int k = 2; k <= DEPTH; k++) begin
        tag_q[k].shade <= tag_q[k - 1].shade;
        tag_q[k].pos_x <= tag_q[k - 1].pos_x;
        tag_q[k].pos_y <= tag_q[k - 1].pos_y;
        tag_q[k].texel <= tag_q[k - 1].texel;
        tag_q[k].dest  <= tag_q[k - 1].dest;
      end
      ins_q[4] <= in_x && in_y;
      for (int k = 5; k <= DEPTH; k++) begin
        ins_q[k] <= ins_q[k - 1];
      end
    end
  end

  bltb_map #(.TEX_MAX_SIDE(TEX_MAX_SIDE), .FRAC_BITS(FRAC_BITS)) u_map_x (
    .clk(clk), .en(adv), .pos(pix_in.pos_x), .org(cfg_q.origin_x),
    .inv(cfg_q.inv_dim_x), .size(cfg_q.tex_width),
    .in_quad(in_x), .fetch(fetch_x), .frac(frac_x)
  );

  bltb_map #(.TEX_MAX_SIDE(TEX_MAX_SIDE), .FRAC_BITS(FRAC_BITS)) u_map_y (
    .clk(clk), .en(adv), .pos(pix_in.pos_y), .org(cfg_q.origin_y),
    .inv(cfg_q.inv_dim_y), .size(cfg_q.tex_height),
    .in_quad(in_y), .fetch(fetch_y), .frac(frac_y)
  );

  bltb_texmem #(.TEX_MAX_SIDE(TEX_MAX_SIDE)) u_texmem (
    .clk(clk), .en(adv), .load(tag_q[3].valid && !tag_q[3].shade),
    .wx(tag_q[3].pos_x), .wy(tag_q[3].pos_y), .wdata(tag_q[3].texel),
    .rx(fetch_x), .ry(fetch_y), .tex(tex)
  );

  bltb_filter #(.FRAC_BITS(FRAC_BITS)) u_filter (
    .clk(clk), .en(adv), .fx(frac_x), .fy(frac_y), .tex(tex), .tf(tf), .ta(ta)
  );

  bltb_blend u_blend (
    .clk(clk), .en(adv), .tf(tf), .ta(ta), .color(cfg_q.color_rgba),
    .dest(tag_q[7].dest), .pix(pix)
  );

  assign pix_out.valid        = tag_q[DEPTH].valid && tag_q[DEPTH].shade;
  assign pix_out.write_enable = ins_q[DEPTH];
  assign pix_out.pixel_out    = ins_q[DEPTH] ? pix : tag_q[DEPTH].dest;
endmodule

[verif/bltb_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the bilinear texture blend pixel unit: watches the pixel, result
// and register channels, predicts each shaded pixel and compares it. Uses bltb_pkg.
module bltb_checker (
  input  logic clk,
  input  logic rst,
  bltb_in_if   pix_in,
  bltb_out_if  pix_out,
  bltb_cfg_if  cfg,
  output int   errors,
  output int   pending,
  output int   pixels_checked
);
  typedef struct {
    logic [31:0] pixel;
    logic        wr_en;
  } shaded_t;

  bltb_pkg::cfg_t regs;
  logic [31:0]    texels [0:65535];
  shaded_t        expected_pixels [$];

  assign pending = expected_pixels.size();

  function automatic longint unsigned eff_size(input logic [8:0] s);
    if (s < 9'd2) return 2;
    if (s > 9'd256) return 256;
    return longint'(s);
  endfunction

  // Maps one axis to a fetch coordinate and an 8-bit fraction; returns the in-quad flag.
  function automatic bit map_axis(input logic [11:0] pos, input logic [23:0] org,
                                  input logic [24:0] inv, input logic [8:0] size,
                                  output int unsigned fetch, output int unsigned frac);
    longint          p;
    longint          u;
    longint unsigned t;
    bit              in_range;
    p = longint'(pos) * 256 - longint'($signed(org));
    u = p * longint'(inv);
    in_range = (u >= 0) && (u <= 64'sh1_0000_0000);
    if (u < 0) u = 0;
    if (u > 64'sh1_0000_0000) u = 64'sh1_0000_0000;
    t = longint'(u) * (eff_size(size) - 2) + 64'h8000_0000;
    fetch = int'(t >> 32);
    frac = int'((t >> 24) & 64'hFF);
    return in_range;
  endfunction

  function automatic longint unsigned div255(input longint unsigned x);
    return (x + 127) / 255;
  endfunction

  function automatic int unsigned root_rounded(input int unsigned v);
    int unsigned s;
    s = 0;
    for (int unsigned b = 256; b != 0; b >>= 1)
      if ((s + b) * (s + b) <= v) s += b;
    if (v > s * s + s) s++;
    return s;
  endfunction

  function automatic shaded_t shade_pixel(input logic [11:0] px, input logic [11:0] py,
                                          input logic [31:0] dest);
    shaded_t         r;
    int unsigned     fx, fy, ax, ay;
    logic [31:0]     s [4];
    longint unsigned w [4];
    longint unsigned acc, a, t, v, c, d, root;
    bit              in_quad;
    in_quad = map_axis(px, regs.origin_x, regs.inv_dim_x, regs.tex_width, fx, ax);
    in_quad &= map_axis(py, regs.origin_y, regs.inv_dim_y, regs.tex_height, fy, ay);
    if (!in_quad) begin
      r.pixel = dest;
      r.wr_en = 1'b0;
      return r;
    end
    s[0] = texels[fy * 256 + fx];
    s[1] = texels[fy * 256 + fx + 1];
    s[2] = texels[(fy + 1) * 256 + fx];
    s[3] = texels[(fy + 1) * 256 + fx + 1];
    w[0] = (256 - ax) * (256 - ay);
    w[1] = ax * (256 - ay);
    w[2] = (256 - ax) * ay;
    w[3] = ax * ay;
    acc = 0;
    for (int i = 0; i < 4; i++) acc += w[i] * s[i][31:24];
    a = (acc + 32768) >> 16;
    a = div255(a * regs.color_rgba[7:0]);
    r.pixel[31:24] = 8'(div255((255 - a) * dest[31:24] + 255 * a));
    for (int ch = 2; ch >= 0; ch--) begin
      acc = 0;
      for (int i = 0; i < 4; i++) begin
        c = (s[i] >> (8 * ch)) & 32'hFF;
        acc += w[i] * c * c;
      end
      t = (acc + 32768) >> 16;
      t = div255(t * ((regs.color_rgba >> (8 * ch + 8)) & 32'hFF));
      if (t > 65025) t = 65025;
      d = (dest >> (8 * ch)) & 32'hFF;
      v = div255((255 - a) * d * d + 255 * t);
      root = root_rounded(int'(v));
      if (root > 255) root = 255;
      r.pixel[8 * ch +: 8] = root[7:0];
    end
    r.wr_en = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    shaded_t want;
    if (rst) begin
      regs <= '{bltb_pkg::ORIGIN_RST, bltb_pkg::ORIGIN_RST, bltb_pkg::INV_DIM_RST,
                bltb_pkg::INV_DIM_RST, bltb_pkg::COLOR_RST, bltb_pkg::TEX_SIZE_RST,
                bltb_pkg::TEX_SIZE_RST};
      expected_pixels.delete();
      errors <= 0;
      pixels_checked <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (bltb_pkg::reg_idx_t'(cfg.index))
          bltb_pkg::REG_ORIGIN_X:  regs.origin_x <= cfg.data[23:0];
          bltb_pkg::REG_ORIGIN_Y:  regs.origin_y <= cfg.data[23:0];
          bltb_pkg::REG_INV_DIM_X: regs.inv_dim_x <= cfg.data[24:0];
          bltb_pkg::REG_INV_DIM_Y: regs.inv_dim_y <= cfg.data[24:0];
          bltb_pkg::REG_COLOR:     regs.color_rgba <= cfg.data;
          bltb_pkg::REG_TEX_W:     regs.tex_width <= cfg.data[8:0];
          bltb_pkg::REG_TEX_H:     regs.tex_height <= cfg.data[8:0];
          default: ;
        endcase
      end
      if (pix_in.valid && pix_in.ready) begin
        if (pix_in.opcode == bltb_pkg::OP_SHADE)
          expected_pixels.push_back(shade_pixel(pix_in.pos_x, pix_in.pos_y, pix_in.dest_pixel));
        else if (pix_in.pos_x < 12'd256 && pix_in.pos_y < 12'd256)
          texels[{pix_in.pos_y[7:0], pix_in.pos_x[7:0]}] = pix_in.texel_word;
      end
      if (pix_out.valid && pix_out.ready) begin
        pixels_checked <= pixels_checked + 1;
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected result pixel %h we %b", $time, pix_out.pixel_out,
                   pix_out.write_enable);
          errors <= errors + 1;
        end else begin
          want = expected_pixels.pop_front();
          if (want.pixel !== pix_out.pixel_out || want.wr_en !== pix_out.write_enable) begin
            $display("%0t: mismatch expected pixel %h we %b, actual pixel %h we %b", $time,
                     want.pixel, want.wr_en, pix_out.pixel_out, pix_out.write_enable);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// Stimulus and verdict for the bilinear texture blend pixel unit.
// Depends on bltb_pkg, the channel interfaces, the unit itself and bltb_checker.
module testbench;
  localparam logic [2:0] REG_SPARE = 3'd7;
  localparam int         CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   src_idle = 17;
  int   sink_idle = 56;
  int   errors, pending, pixels_checked;
  int   items_sent = 0;
  int   quad_x, quad_w;
  bltb_pkg::cfg_t regs;

  bltb_in_if  pix_in ();
  bltb_out_if pix_out ();
  bltb_cfg_if cfg ();

  bilinear_texture_blend_pixel_unit u_top (
    .clk(clk), .rst(rst), .pix_in(pix_in), .pix_out(pix_out), .cfg(cfg)
  );

  bltb_checker u_chk (
    .clk(clk), .rst(rst), .pix_in(pix_in), .pix_out(pix_out), .cfg(cfg),
    .errors(errors), .pending(pending), .pixels_checked(pixels_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    pix_in.valid = 1'b0;
    pix_in.opcode = bltb_pkg::OP_LOAD;
    pix_in.pos_x = '0;
    pix_in.pos_y = '0;
    pix_in.texel_word = '0;
    pix_in.dest_pixel = '0;
    pix_out.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = bltb_pkg::REG_ORIGIN_X;
    cfg.data = '0;
  end

  always @(posedge clk) begin
    if (rst) pix_out.ready <= 1'b0;
    else pix_out.ready <= ($urandom_range(99) >= sink_idle);
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("testbench: FAIL");
    $finish;
  end

  // Valid is only lowered during idle cycles, so back-to-back transfers keep it high.
  task automatic push_item(input logic op, input logic [11:0] x, input logic [11:0] y,
                           input logic [31:0] word);
    while ($urandom_range(99) < src_idle) begin
      pix_in.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.opcode <= op;
    pix_in.pos_x <= x;
    pix_in.pos_y <= y;
    pix_in.texel_word <= (op == bltb_pkg::OP_LOAD) ? word : $urandom;
    pix_in.dest_pixel <= (op == bltb_pkg::OP_SHADE) ? word : $urandom;
    do @(posedge clk); while (!pix_in.ready);
    items_sent++;
  endtask

  // Waits until the unit is drained, then writes every register plus the spare index.
  task automatic write_regs();
    logic [2:0]  idx [8];
    logic [31:0] val [8];
    idx = '{bltb_pkg::REG_ORIGIN_X, bltb_pkg::REG_ORIGIN_Y, bltb_pkg::REG_INV_DIM_X,
            bltb_pkg::REG_INV_DIM_Y, bltb_pkg::REG_COLOR, bltb_pkg::REG_TEX_W,
            bltb_pkg::REG_TEX_H, REG_SPARE};
    val = '{32'(regs.origin_x), 32'(regs.origin_y), 32'(regs.inv_dim_x),
            32'(regs.inv_dim_y), regs.color_rgba, 32'(regs.tex_width),
            32'(regs.tex_height), $urandom};
    pix_in.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      cfg.valid <= 1'b1;
      cfg.index <= idx[i];
      cfg.data <= val[i];
      do @(posedge clk); while (!cfg.ready);
    end
    cfg.valid <= 1'b0;
  endtask

  function automatic logic [31:0] some_word();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int          ox;
    logic [11:0] sx, sy;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Columns and rows 0 to 15, 254 and 255 are filled first; every shade below is kept
    // to fetches inside that set, so none ever reads an unwritten texel.
    for (int y = 0; y < 18; y++)
      for (int x = 0; x < 18; x++)
        push_item(bltb_pkg::OP_LOAD, 12'((x < 16) ? x : x + 238),
                  12'((y < 16) ? y : y + 238), some_word());

    // Defaults map pixel 0 to U=0 and pixel 1 to U=1; bright texels over a white
    // destination overflow the root and must saturate.
    push_item(bltb_pkg::OP_LOAD, 12'd0, 12'd0, 32'h00FFFFFF);
    push_item(bltb_pkg::OP_LOAD, 12'd1, 12'd0, 32'hFF000000);
    push_item(bltb_pkg::OP_LOAD, 12'd0, 12'd1, 32'h80FF00FF);
    push_item(bltb_pkg::OP_LOAD, 12'd255, 12'd255, 32'hFFFFFFFF);
    push_item(bltb_pkg::OP_LOAD, 12'd256, 12'd0, 32'h12345678);
    push_item(bltb_pkg::OP_LOAD, 12'd4095, 12'd4095, 32'h0);
    push_item(bltb_pkg::OP_SHADE, 12'd0, 12'd0, 32'hFFFFFFFF);
    push_item(bltb_pkg::OP_SHADE, 12'd0, 12'd0, 32'h00000000);
    push_item(bltb_pkg::OP_SHADE, 12'd1, 12'd0, 32'h7F7F7F7F);
    push_item(bltb_pkg::OP_SHADE, 12'd0, 12'd1, 32'hFFFFFFFF);
    push_item(bltb_pkg::OP_SHADE, 12'd1, 12'd1, 32'h00FFFFFF);
    push_item(bltb_pkg::OP_SHADE, 12'd2, 12'd0, 32'hA5A5A5A5);
    push_item(bltb_pkg::OP_SHADE, 12'd0, 12'd2, 32'h5A5A5A5A);
    push_item(bltb_pkg::OP_SHADE, 12'd4095, 12'd4095, 32'hFFFFFFFF);
    push_item(bltb_pkg::OP_SHADE, 12'd0, 12'd4095, 32'h0);

    for (int phase = 0; phase < 12; phase++) begin
      if (phase == 4) begin
        src_idle = 56;
        sink_idle = 17;
      end else if (phase == 8) begin
        src_idle = 0;
        sink_idle = 0;
      end
      quad_w = $urandom_range(1, 300);
      quad_x = $urandom_range(0, 3700);
      ox = quad_x * 256 + $urandom_range(0, 255);
      regs.origin_x = 24'(ox);
      regs.origin_y = 24'(ox + $urandom_range(0, 40) * 256);
      regs.inv_dim_x = 25'((32'h1000000 + quad_w / 2) / quad_w);
      regs.inv_dim_y = 25'((32'h1000000 + quad_w / 2) / quad_w);
      regs.color_rgba = some_word();
      regs.tex_width = 9'($urandom_range(2, 16));
      regs.tex_height = 9'($urandom_range(2, 16));
      // With a full-size texture the quad is one pixel on a whole-pixel origin, so the
      // fetch lands only on the first or the last two texels of that axis.
      case (phase)
        0: begin regs.origin_x = 24'h800000; regs.tex_width = 9'd0; end
        1: begin regs.origin_y = 24'h7FFFFF; regs.tex_height = 9'd1; end
        2: begin regs.inv_dim_x = 25'd0; regs.tex_width = 9'd511; end
        3: begin
          regs.inv_dim_y = 25'h1000000;
          regs.origin_y = {regs.origin_y[23:8], 8'h00};
          regs.tex_height = 9'd256;
        end
        4: begin regs.color_rgba = 32'h0; regs.tex_width = 9'd2; regs.tex_height = 9'd2; end
        5: begin
          regs.color_rgba = 32'hFFFFFFFF;
          regs.inv_dim_x = 25'h1000000;
          regs.origin_x = {regs.origin_x[23:8], 8'h00};
          regs.tex_width = 9'd256;
        end
        6: begin regs.origin_x = 24'hFFF000; regs.tex_height = 9'($urandom_range(0, 16)); end
        default: ;
      endcase
      write_regs();
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(99) < 20) begin
          if ($urandom_range(9) == 0)
            push_item(bltb_pkg::OP_LOAD, 12'($urandom), 12'($urandom), $urandom);
          else push_item(bltb_pkg::OP_LOAD, 12'($urandom_range(255)),
                         12'($urandom_range(255)), some_word());
        end else begin
          if ($urandom_range(99) < 85) begin
            sx = 12'(quad_x + $urandom_range(0, quad_w + 3) - 1);
            sy = 12'(int'(regs.origin_y) / 256 + $urandom_range(0, quad_w + 3) - 1);
          end else begin
            sx = 12'($urandom);
            sy = 12'($urandom);
          end
          push_item(bltb_pkg::OP_SHADE, sx, sy, some_word());
        end
      end
    end

    pix_in.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("sent %0d items (texture fill, loads, shades) over 12 register settings",
             items_sent);
    $display("checked %0d result pixels, %0d mismatches", pixels_checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
